@@ src/i2cseq_pkg.sv @@
// Shared types and codes for the I2C register transaction sequencer.
// No dependencies; imported by every module of the block.
package i2cseq_pkg;

    localparam int OP_W   = 3;
    localparam int CMD_W  = 3;
    localparam int LIM_W  = 16;
    localparam int BYTE_W = 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_BEGIN_RD = 3'd0;
    localparam logic [OP_W-1:0] OP_BEGIN_WR = 3'd1;
    localparam logic [OP_W-1:0] OP_STATUS   = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK     = 3'd3;
    localparam logic [OP_W-1:0] OP_WBYTE    = 3'd4;

    // commands to the byte engine
    localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEND  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RACK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RNACK = 3'd4;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_NEED  = 3'd6;

    // engine status codes after masking
    localparam logic [BYTE_W-1:0] STATUS_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] ST_START    = 8'h08;
    localparam logic [BYTE_W-1:0] ST_RSTART   = 8'h10;
    localparam logic [BYTE_W-1:0] ST_ADDR_W   = 8'h18;
    localparam logic [BYTE_W-1:0] ST_DATA_TX  = 8'h28;
    localparam logic [BYTE_W-1:0] ST_ADDR_R   = 8'h40;
    localparam logic [BYTE_W-1:0] ST_DATA_ACK = 8'h50;
    localparam logic [BYTE_W-1:0] ST_DATA_NAK = 8'h58;

    localparam logic [LIM_W-1:0] TIMEOUT_RESET = 16'd10000;
    localparam logic [LIM_W-1:0] TICK_MAX      = 16'hFFFF;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START     = 4'd1,
        PH_ADDR_W    = 4'd2,
        PH_REG       = 4'd3,
        PH_RSTART    = 4'd4,
        PH_ADDR_R    = 4'd5,
        PH_RD_ACK    = 4'd6,
        PH_RD_NACK   = 4'd7,
        PH_NEED_DATA = 4'd8,
        PH_DATA_W    = 4'd9
    } phase_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [6:0]        device_address;
        logic [BYTE_W-1:0] register_address;
        logic [15:0]       byte_count;
        logic [BYTE_W-1:0] write_byte;
        logic [BYTE_W-1:0] status_code;
        logic [BYTE_W-1:0] received_byte;
    } item_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] send_byte;
        logic              read_valid;
        logic [BYTE_W-1:0] read_byte;
        logic              done_res;
        logic              error;
    } result_t;

endpackage

@@ src/i2cseq_core.sv @@
// Transaction phase machine: state registers and next-state/result logic.
// Depends on i2cseq_pkg.
module i2cseq_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  i2cseq_pkg::item_t            item,
    input  logic [i2cseq_pkg::LIM_W-1:0] timeout_limit,
    input  logic                         out_free,
    output logic                         consume,
    output logic                         res_load,
    output i2cseq_pkg::result_t          res
);
    import i2cseq_pkg::*;

    localparam int CW = COUNT_WIDTH;

    phase_t            phase_reg, phase_next;
    logic              is_read_reg, is_read_next;
    logic [6:0]        addr_reg, addr_next;
    logic [BYTE_W-1:0] regaddr_reg, regaddr_next;
    logic [CW-1:0]     total_reg, total_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [LIM_W-1:0]  wait_reg, wait_next;

    logic              has_res;
    logic [BYTE_W-1:0] st;
    logic [CW-1:0]     cnt_inc;
    logic [CW:0]       eff_total;
    logic              more_rd_cur, more_rd_inc;
    logic [LIM_W-1:0]  wait_sat;

    assign consume  = item_valid && (!has_res || out_free);
    assign res_load = consume && has_res;

    assign st        = item.status_code & STATUS_MASK;
    assign cnt_inc   = cnt_reg + CW'(1);
    // a read length of zero behaves as one byte
    assign eff_total = (total_reg == '0) ? (CW+1)'(1) : {1'b0, total_reg};
    assign more_rd_cur = ({1'b0, cnt_reg} + (CW+1)'(1)) < eff_total;
    assign more_rd_inc = ({1'b0, cnt_inc} + (CW+1)'(1)) < eff_total;
    assign wait_sat  = (wait_reg == TICK_MAX) ? wait_reg : wait_reg + LIM_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            is_read_reg <= 1'b0;
            addr_reg    <= '0;
            regaddr_reg <= '0;
            total_reg   <= '0;
            cnt_reg     <= '0;
            wait_reg    <= '0;
        end
        else if (consume)
        begin
            phase_reg   <= phase_next;
            is_read_reg <= is_read_next;
            addr_reg    <= addr_next;
            regaddr_reg <= regaddr_next;
            total_reg   <= total_next;
            cnt_reg     <= cnt_next;
            wait_reg    <= wait_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        is_read_next = is_read_reg;
        addr_next    = addr_reg;
        regaddr_next = regaddr_reg;
        total_next   = total_reg;
        cnt_next     = cnt_reg;
        wait_next    = wait_reg;
        has_res      = 1'b0;
        res          = '0;
        res.command  = CMD_NONE;

        case (item.operation)
            OP_BEGIN_RD, OP_BEGIN_WR:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    is_read_next = (item.operation == OP_BEGIN_RD);
                    addr_next    = item.device_address;
                    regaddr_next = item.register_address;
                    total_next   = CW'(item.byte_count);
                    cnt_next     = '0;
                    phase_next   = PH_START;
                    wait_next    = '0;
                    has_res      = 1'b1;
                    res.command  = CMD_START;
                end
            end
            OP_TICK:
            begin
                if (phase_reg != PH_IDLE && phase_reg != PH_NEED_DATA)
                begin
                    wait_next = wait_sat;
                    if (wait_sat >= timeout_limit)
                    begin
                        phase_next   = PH_IDLE;
                        wait_next    = '0;
                        has_res      = 1'b1;
                        res.command  = CMD_STOP;
                        res.done_res = 1'b1;
                        res.error    = 1'b1;
                    end
                end
            end
            OP_WBYTE:
            begin
                if (phase_reg == PH_NEED_DATA)
                begin
                    phase_next    = PH_DATA_W;
                    wait_next     = '0;
                    has_res       = 1'b1;
                    res.command   = CMD_SEND;
                    res.send_byte = item.write_byte;
                end
            end
            OP_STATUS:
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        if (st == ST_START)
                        begin
                            phase_next    = PH_ADDR_W;
                            wait_next     = '0;
                            has_res       = 1'b1;
                            res.command   = CMD_SEND;
                            res.send_byte = {addr_reg, 1'b0};
                        end
                    end
                    PH_ADDR_W:
                    begin
                        if (st == ST_ADDR_W)
                        begin
                            phase_next    = PH_REG;
                            wait_next     = '0;
                            has_res       = 1'b1;
                            res.command   = CMD_SEND;
                            res.send_byte = regaddr_reg;
                        end
                    end
                    PH_REG:
                    begin
                        if (st == ST_DATA_TX)
                        begin
                            wait_next = '0;
                            has_res   = 1'b1;
                            if (is_read_reg)
                            begin
                                phase_next  = PH_RSTART;
                                res.command = CMD_START;
                            end
                            else if (cnt_reg < total_reg)
                            begin
                                phase_next  = PH_NEED_DATA;
                                res.command = CMD_NEED;
                            end
                            else
                            begin
                                phase_next   = PH_IDLE;
                                res.command  = CMD_STOP;
                                res.done_res = 1'b1;
                            end
                        end
                    end
                    PH_RSTART:
                    begin
                        if (st == ST_RSTART)
                        begin
                            phase_next    = PH_ADDR_R;
                            wait_next     = '0;
                            has_res       = 1'b1;
                            res.command   = CMD_SEND;
                            res.send_byte = {addr_reg, 1'b1};
                        end
                    end
                    PH_ADDR_R:
                    begin
                        if (st == ST_ADDR_R)
                        begin
                            wait_next   = '0;
                            has_res     = 1'b1;
                            phase_next  = more_rd_cur ? PH_RD_ACK : PH_RD_NACK;
                            res.command = more_rd_cur ? CMD_RACK : CMD_RNACK;
                        end
                    end
                    PH_RD_ACK:
                    begin
                        if (st == ST_DATA_ACK)
                        begin
                            cnt_next       = cnt_inc;
                            wait_next      = '0;
                            has_res        = 1'b1;
                            phase_next     = more_rd_inc ? PH_RD_ACK : PH_RD_NACK;
                            res.command    = more_rd_inc ? CMD_RACK : CMD_RNACK;
                            res.read_valid = 1'b1;
                            res.read_byte  = item.received_byte;
                        end
                    end
                    PH_RD_NACK:
                    begin
                        if (st == ST_DATA_NAK)
                        begin
                            phase_next     = PH_IDLE;
                            wait_next      = '0;
                            has_res        = 1'b1;
                            res.command    = CMD_STOP;
                            res.read_valid = 1'b1;
                            res.read_byte  = item.received_byte;
                            res.done_res   = 1'b1;
                        end
                    end
                    PH_DATA_W:
                    begin
                        if (st == ST_DATA_TX)
                        begin
                            cnt_next  = cnt_inc;
                            wait_next = '0;
                            has_res   = 1'b1;
                            if (cnt_inc < total_reg)
                            begin
                                phase_next  = PH_NEED_DATA;
                                res.command = CMD_NEED;
                            end
                            else
                            begin
                                phase_next   = PH_IDLE;
                                res.command  = CMD_STOP;
                                res.done_res = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        has_res = 1'b0;
                    end
                endcase
            end
            default:
            begin
                has_res = 1'b0;
            end
        endcase
    end

endmodule

@@ src/i2cseq_out_reg.sv @@
// Result register on the master side; holds one result until taken.
// Depends on i2cseq_pkg.
module i2cseq_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  i2cseq_pkg::result_t res,
    input  logic                take,
    output logic                free,
    output logic                valid,
    output i2cseq_pkg::result_t data
);
    import i2cseq_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign free  = !valid_reg || take;
    assign valid = valid_reg;
    assign data  = data_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

endmodule

@@ src/i2c_register_transaction_sequencer_unit.sv @@
// I2C register read/write sequencer, top level.
// An accepted event reaches m_axis as a result through the input register
// and then the result register. Throughput: one event per cycle;
// an event that yields a result waits in the input register while the
// result register is full and not being taken. Reset (async, active low)
// returns the phase to idle, clears counters and sets timeout_limit to 10000.
module i2c_register_transaction_sequencer_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,     // timeout_limit
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // device_address[6:0], register_address[14:7], byte_count[30:15],
    // write_byte[38:31], status_code[46:39], received_byte[54:47], pad[55]
    input  logic [55:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,  // operation[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // send_byte[7:0], read_byte[15:8], error[16], pad[23:17]
    output logic [23:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser,  // command[2:0], read_valid[3]
    output logic        m_axis_tlast   // done_res
);
    import i2cseq_pkg::*;

    logic [LIM_W-1:0] limit_reg;
    logic             in_valid_reg, in_valid_next;
    item_t            in_item_reg;
    item_t            s_item;
    logic             accept;
    logic             consume;
    logic             res_load;
    logic             out_free;
    result_t          res;
    result_t          out_data;

    assign s_item.operation        = s_axis_tuser;
    assign s_item.device_address   = s_axis_tdata[6:0];
    assign s_item.register_address = s_axis_tdata[14:7];
    assign s_item.byte_count       = s_axis_tdata[30:15];
    assign s_item.write_byte       = s_axis_tdata[38:31];
    assign s_item.status_code      = s_axis_tdata[46:39];
    assign s_item.received_byte    = s_axis_tdata[54:47];

    assign s_axis_tready = !in_valid_reg || consume;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= TIMEOUT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (consume)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= s_item;
    end

    i2cseq_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (in_valid_reg),
        .item         (in_item_reg),
        .timeout_limit(limit_reg),
        .out_free     (out_free),
        .consume      (consume),
        .res_load     (res_load),
        .res          (res)
    );

    i2cseq_out_reg u_out (
        .clk  (clk),
        .rst_n(rst_n),
        .load (res_load),
        .res  (res),
        .take (m_axis_tready),
        .free (out_free),
        .valid(m_axis_tvalid),
        .data (out_data)
    );

    assign m_axis_tdata = {7'd0, out_data.error, out_data.read_byte, out_data.send_byte};
    assign m_axis_tuser = {out_data.read_valid, out_data.command};
    assign m_axis_tlast = out_data.done_res;

endmodule

@@ src/i2cseq_checker.sv @@
// Port-level checks for the sequencer top level, attached by bind.
// Depends on i2cseq_pkg and i2c_register_transaction_sequencer_unit.
module i2cseq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import i2cseq_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
    else $error("stalled result changed");

    // a transaction always ends with stop
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[2:0] == CMD_STOP)
    else $error("end of transaction without stop");

    // timeout ends the transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tlast)
    else $error("error flag on a non-final result");

    // received data only with a receive or the closing stop
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[3] |->
            m_axis_tuser[2:0] == CMD_RACK || m_axis_tuser[2:0] == CMD_RNACK
            || m_axis_tuser[2:0] == CMD_STOP)
    else $error("read data with wrong command");

    // transmit byte is zero unless sending
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2:0] != CMD_SEND |-> m_axis_tdata[7:0] == 8'd0)
    else $error("send byte set without send command");

endmodule

bind i2c_register_transaction_sequencer_unit i2cseq_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);
